FILE: hw/rtl/bresenham_line_rasterizer_unit_defines.svh
// ----------------------------------------------------------------------------
// Bresenham line rasterizer - assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while the synchronous active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef BRESENHAM_LINE_RASTERIZER_UNIT_DEFINES_SVH
`define BRESENHAM_LINE_RASTERIZER_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define BRL_ASSERT_SAME(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |-> (cons)) \
    else $error("rasterizer check failed (same cycle)");

// Consequent must hold in the cycle after the antecedent
`define BRL_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |=> (cons)) \
    else $error("rasterizer check failed (next cycle)");

`endif

FILE: hw/rtl/brl_pkg.sv
// ----------------------------------------------------------------------------
// brl_pkg
// Shared constants, codes and types of the Bresenham line rasterizer.
// ----------------------------------------------------------------------------
`default_nettype none

package brl_pkg;

  // Default widths
  localparam int COORD_BITS_DEF = 14;
  localparam int INDEX_BITS_DEF = 24;

  // Fixed field widths
  localparam int REG_BITS       = 13;
  localparam int COLOR_BITS     = 24;
  localparam int CFG_INDEX_BITS = 2;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Operation codes
  localparam logic OP_START = 1'b0;

  // Configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] CFG_VIEW_WIDTH  = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] CFG_VIEW_HEIGHT = CFG_INDEX_BITS'(1);

  // Register reset values
  localparam logic [REG_BITS-1:0] VIEW_WIDTH_RESET  = REG_BITS'(1280);
  localparam logic [REG_BITS-1:0] VIEW_HEIGHT_RESET = REG_BITS'(720);

  // Walker status towards the top level
  typedef struct packed {
    logic pop;
    logic emit;
  } walk_stat_t;

  // Packed command width: three flags, start x/y, major end, decision,
  // two doubled deltas and the colour
  function automatic int cmd_bits(int cb);
    return 3 * cb + (cb + 4) + 2 * (cb + 2) + 3 + COLOR_BITS;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/brl_in_if.sv
// ----------------------------------------------------------------------------
// brl_in_if
// Input channel of the rasterizer: start and tick commands.
// ----------------------------------------------------------------------------
`default_nettype none

interface brl_in_if #(
  parameter int COORD_BITS = brl_pkg::COORD_BITS_DEF
);
  logic                              valid;
  logic                              ready;
  logic                              op;
  logic signed [COORD_BITS-1:0]      start_x;
  logic signed [COORD_BITS-1:0]      start_y;
  logic signed [COORD_BITS-1:0]      end_x;
  logic signed [COORD_BITS-1:0]      end_y;
  logic [brl_pkg::COLOR_BITS-1:0]    color_rgb;

  modport source (output valid, op, start_x, start_y, end_x, end_y, color_rgb,
                  input ready);
  modport sink   (input valid, op, start_x, start_y, end_x, end_y, color_rgb,
                  output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/brl_out_if.sv
// ----------------------------------------------------------------------------
// brl_out_if
// Result channel of the rasterizer: one pixel per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface brl_out_if #(
  parameter int COORD_BITS = brl_pkg::COORD_BITS_DEF,
  parameter int INDEX_BITS = brl_pkg::INDEX_BITS_DEF
);
  logic                              valid;
  logic                              ready;
  logic signed [COORD_BITS-1:0]      pixel_x;
  logic signed [COORD_BITS-1:0]      pixel_y;
  logic [INDEX_BITS-1:0]             pixel_index;
  logic                              inside_res;
  logic [brl_pkg::COLOR_BITS-1:0]    pixel_color;
  logic                              last;

  modport source (output valid, pixel_x, pixel_y, pixel_index, inside_res,
                  pixel_color, last, input ready);
  modport sink   (input valid, pixel_x, pixel_y, pixel_index, inside_res,
                  pixel_color, last, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/brl_cfg_if.sv
// ----------------------------------------------------------------------------
// brl_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface brl_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [brl_pkg::CFG_INDEX_BITS-1:0]  index;
  logic [brl_pkg::REG_BITS-1:0]        data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/bresenham_line_rasterizer_unit.sv
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer_unit
// Integer line rasterizer producing at most one pixel per command.
// in_ch takes commands: op start carries two endpoints and a colour and
// yields the first pixel; op tick yields the next pixel of the running
// line, and nothing when no line runs. A start drops any running line.
// out_ch gives one pixel per transaction with coordinates, viewport flag,
// framebuffer index (x + y * view_width, zero outside) and a last marker.
// cfg_ch writes view_width (index 0) and view_height (index 1) and is always
// ready; the user writes it only while the block is idle (not enforced).
// A pixel passes the classify register, a queue entry, the walk register
// and the output register on its way to out_ch. Throughput: one command
// per cycle while out_ch does not stall; the walk register steps the
// line by adds and compares, the output stage does the stride multiply.
// A two-entry command queue parts front and walker; when out_ch stalls
// the pipeline fills and in_ch drops ready once the queue is full and
// the classify register holds a command. Reset (rst_n low, synchronous)
// empties all stages, ends any line and sets the viewport to 1280 x 720.
// ----------------------------------------------------------------------------
`default_nettype none
`include "bresenham_line_rasterizer_unit_defines.svh"

module bresenham_line_rasterizer_unit #(
  parameter int COORD_BITS = brl_pkg::COORD_BITS_DEF,
  parameter int INDEX_BITS = brl_pkg::INDEX_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  brl_in_if.sink    in_ch,
  brl_out_if.source out_ch,
  brl_cfg_if.sink   cfg_ch
);

  localparam int CMD_W = brl_pkg::cmd_bits(COORD_BITS);

  // Front to queue
  logic             f_valid, f_ready;
  logic [CMD_W-1:0] f_cmd;
  // Queue to walker
  logic             q_valid, q_ready;
  logic [CMD_W-1:0] q_cmd;
  // Walker to output stage
  logic                           p_valid, p_ready, p_last;
  logic signed [COORD_BITS-1:0]   p_x, p_y;
  logic [brl_pkg::COLOR_BITS-1:0] p_color;
  brl_pkg::walk_stat_t            walk_stat;

  brl_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd       (f_cmd)
  );

  brl_queue #(.DATA_W(CMD_W), .DEPTH(brl_pkg::QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (f_cmd),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_cmd)
  );

  brl_walk #(.COORD_BITS(COORD_BITS)) u_walk (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd       (q_cmd),
    .pix_valid (p_valid),
    .pix_ready (p_ready),
    .pix_x     (p_x),
    .pix_y     (p_y),
    .pix_color (p_color),
    .pix_last  (p_last),
    .stat      (walk_stat)
  );

  brl_emit #(.COORD_BITS(COORD_BITS), .INDEX_BITS(INDEX_BITS)) u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .pix_valid (p_valid),
    .pix_ready (p_ready),
    .pix_x     (p_x),
    .pix_y     (p_y),
    .pix_color (p_color),
    .pix_last  (p_last),
    .cfg_ch    (cfg_ch),
    .out_ch    (out_ch)
  );

  // Checks
  // walker only takes commands that the queue holds
  `BRL_ASSERT_SAME(a_pop_needs_entry, clk, rst_n, walk_stat.pop, q_valid)
  // every emitted pixel lands in the pixel register
  `BRL_ASSERT_NEXT(a_emit_fills_pixel, clk, rst_n, walk_stat.emit, p_valid)
  // a pixel flagged inside never has a negative coordinate
  `BRL_ASSERT_SAME(a_inside_nonneg, clk, rst_n, out_ch.valid && out_ch.inside_res,
                   !out_ch.pixel_x[COORD_BITS-1] && !out_ch.pixel_y[COORD_BITS-1])

endmodule

`default_nettype wire

FILE: hw/rtl/brl_front.sv
// ----------------------------------------------------------------------------
// brl_front
// Accepts commands, measures the deltas and classifies the line (steep or
// shallow, endpoint swap), then builds the walk command for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module brl_front #(
  parameter int COORD_BITS = brl_pkg::COORD_BITS_DEF
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  brl_in_if.sink                                         in_ch,
  output logic                                           cmd_valid,
  input  logic                                           cmd_ready,
  output logic [brl_pkg::cmd_bits(COORD_BITS)-1:0]       cmd
);

  localparam int CB    = COORD_BITS;
  localparam int D_W   = CB + 1;
  localparam int T_W   = CB + 2;
  localparam int DEC_W = CB + 4;

  typedef struct packed {
    logic                           is_start;
    logic                           steep;
    logic                           minor_neg;
    logic signed [CB-1:0]           start_x;
    logic signed [CB-1:0]           start_y;
    logic signed [CB-1:0]           major_end;
    logic signed [DEC_W-1:0]        decision;
    logic [T_W-1:0]                 twice_minor;
    logic [T_W-1:0]                 twice_major;
    logic [brl_pkg::COLOR_BITS-1:0] color;
  } cmd_t;

  // Classify stage registers
  logic                           s1_valid_r, s1_valid_nxt;
  logic                           s1_op_r;
  logic signed [CB-1:0]           s1_x0_r, s1_y0_r, s1_x1_r, s1_y1_r;
  logic [CB-1:0]                  s1_adx_r, s1_ady_r;
  logic                           s1_dxneg_r, s1_dxpos_r, s1_dyneg_r, s1_dypos_r;
  logic                           s1_steep_r;
  logic [brl_pkg::COLOR_BITS-1:0] s1_color_r;

  logic                           s1_adv;
  logic signed [D_W-1:0]          dx, dy, adx_full, ady_full;
  logic [CB-1:0]                  adx, ady;

  // Delta magnitudes of the incoming endpoints
  always_comb begin
    dx       = D_W'(in_ch.end_x) - D_W'(in_ch.start_x);
    dy       = D_W'(in_ch.end_y) - D_W'(in_ch.start_y);
    adx_full = dx[D_W-1] ? -dx : dx;
    ady_full = dy[D_W-1] ? -dy : dy;
    adx      = adx_full[CB-1:0];
    ady      = ady_full[CB-1:0];
  end

  assign s1_adv      = !s1_valid_r || cmd_ready;
  assign in_ch.ready = s1_adv;
  assign s1_valid_nxt = s1_adv ? in_ch.valid : s1_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && in_ch.valid) begin
      s1_op_r    <= in_ch.op;
      s1_x0_r    <= in_ch.start_x;
      s1_y0_r    <= in_ch.start_y;
      s1_x1_r    <= in_ch.end_x;
      s1_y1_r    <= in_ch.end_y;
      s1_adx_r   <= adx;
      s1_ady_r   <= ady;
      s1_dxneg_r <= dx[D_W-1];
      s1_dxpos_r <= !dx[D_W-1] && (dx != '0);
      s1_dyneg_r <= dy[D_W-1];
      s1_dypos_r <= !dy[D_W-1] && (dy != '0);
      s1_steep_r <= !(ady < adx);
      s1_color_r <= in_ch.color_rgb;
    end
  end

  // Command build: swap so the major axis runs upward
  logic          swap;
  logic [CB-1:0] amin, amaj;
  cmd_t          cmd_s;

  always_comb begin
    swap = s1_steep_r ? s1_dyneg_r : s1_dxneg_r;
    amin = s1_steep_r ? s1_adx_r : s1_ady_r;
    amaj = s1_steep_r ? s1_ady_r : s1_adx_r;

    cmd_s.is_start  = (s1_op_r == brl_pkg::OP_START);
    cmd_s.steep     = s1_steep_r;
    if (s1_steep_r) begin
      cmd_s.minor_neg = swap ? s1_dxpos_r : s1_dxneg_r;
      cmd_s.major_end = swap ? s1_y0_r : s1_y1_r;
    end else begin
      cmd_s.minor_neg = swap ? s1_dypos_r : s1_dyneg_r;
      cmd_s.major_end = swap ? s1_x0_r : s1_x1_r;
    end
    cmd_s.start_x     = swap ? s1_x1_r : s1_x0_r;
    cmd_s.start_y     = swap ? s1_y1_r : s1_y0_r;
    cmd_s.twice_minor = T_W'({amin, 1'b0});
    cmd_s.twice_major = T_W'({amaj, 1'b0});
    cmd_s.decision    = $signed(DEC_W'({amin, 1'b0})) - $signed(DEC_W'(amaj));
    cmd_s.color       = s1_color_r;
  end

  assign cmd_valid = s1_valid_r;
  assign cmd       = cmd_s;

endmodule

`default_nettype wire

FILE: hw/rtl/brl_queue.sv
// ----------------------------------------------------------------------------
// brl_queue
// Short first-in first-out queue of walk commands between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module brl_queue #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = brl_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_valid,
  output logic              wr_ready,
  input  logic [DATA_W-1:0] wr_data,
  output logic              rd_valid,
  input  logic              rd_ready,
  output logic [DATA_W-1:0] rd_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              push, pop;

  assign wr_ready = (count_r != CNT_W'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/brl_walk.sv
// ----------------------------------------------------------------------------
// brl_walk
// Back end: holds the line walk state, takes one command per cycle unless
// a pixel is stalled; gives one pixel per start or per tick of a running line.
// ----------------------------------------------------------------------------
`default_nettype none

module brl_walk #(
  parameter int COORD_BITS = brl_pkg::COORD_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     cmd_valid,
  output logic                                     cmd_ready,
  input  logic [brl_pkg::cmd_bits(COORD_BITS)-1:0] cmd,
  output logic                                     pix_valid,
  input  logic                                     pix_ready,
  output logic signed [COORD_BITS-1:0]             pix_x,
  output logic signed [COORD_BITS-1:0]             pix_y,
  output logic [brl_pkg::COLOR_BITS-1:0]           pix_color,
  output logic                                     pix_last,
  output brl_pkg::walk_stat_t                      stat
);

  localparam int CB    = COORD_BITS;
  localparam int T_W   = CB + 2;
  localparam int DEC_W = CB + 4;

  typedef struct packed {
    logic                           is_start;
    logic                           steep;
    logic                           minor_neg;
    logic signed [CB-1:0]           start_x;
    logic signed [CB-1:0]           start_y;
    logic signed [CB-1:0]           major_end;
    logic signed [DEC_W-1:0]        decision;
    logic [T_W-1:0]                 twice_minor;
    logic [T_W-1:0]                 twice_major;
    logic [brl_pkg::COLOR_BITS-1:0] color;
  } cmd_t;

  // Walk state
  logic signed [CB-1:0]           cur_x_r, cur_y_r, major_end_r;
  logic signed [DEC_W-1:0]        decision_r;
  logic [T_W-1:0]                 tmin_r, tmaj_r;
  logic                           neg_r, steep_r;
  logic                           active_r, active_nxt;
  logic [brl_pkg::COLOR_BITS-1:0] color_r;

  // Pixel register
  logic                           pix_valid_r, pix_valid_nxt;
  logic signed [CB-1:0]           pix_x_r, pix_y_r;
  logic [brl_pkg::COLOR_BITS-1:0] pix_color_r;
  logic                           pix_last_r;

  cmd_t                           cmd_s;
  logic                           slot_free, pop, emit, last, dec_pos;
  logic signed [CB-1:0]           e_x, e_y, e_end, major, minor, major_nxt, minor_nxt;
  logic signed [CB-1:0]           nx_x, nx_y;
  logic signed [DEC_W-1:0]        e_dec, dec_sub, dec_nxt;
  logic [T_W-1:0]                 e_tmin, e_tmaj;
  logic                           e_neg, e_steep;
  logic [brl_pkg::COLOR_BITS-1:0] e_color;

  assign cmd_s     = cmd_t'(cmd);
  assign slot_free = !pix_valid_r || pix_ready;
  assign cmd_ready = slot_free;
  assign pop       = cmd_valid && slot_free;
  assign emit      = pop && (cmd_s.is_start || active_r);

  // Working state: a start command replaces the held line
  always_comb begin
    if (cmd_s.is_start) begin
      e_x     = cmd_s.start_x;
      e_y     = cmd_s.start_y;
      e_end   = cmd_s.major_end;
      e_dec   = cmd_s.decision;
      e_tmin  = cmd_s.twice_minor;
      e_tmaj  = cmd_s.twice_major;
      e_neg   = cmd_s.minor_neg;
      e_steep = cmd_s.steep;
      e_color = cmd_s.color;
    end else begin
      e_x     = cur_x_r;
      e_y     = cur_y_r;
      e_end   = major_end_r;
      e_dec   = decision_r;
      e_tmin  = tmin_r;
      e_tmaj  = tmaj_r;
      e_neg   = neg_r;
      e_steep = steep_r;
      e_color = color_r;
    end
  end

  // One Bresenham step
  always_comb begin
    major     = e_steep ? e_y : e_x;
    minor     = e_steep ? e_x : e_y;
    last      = (major >= e_end);
    dec_pos   = !e_dec[DEC_W-1] && (e_dec != '0);
    major_nxt = major + CB'(1);
    minor_nxt = minor;
    dec_sub   = e_dec;
    if (dec_pos) begin
      minor_nxt = e_neg ? minor - CB'(1) : minor + CB'(1);
      dec_sub   = e_dec - $signed(DEC_W'(e_tmaj));
    end
    dec_nxt = dec_sub + $signed(DEC_W'(e_tmin));
    nx_x    = e_steep ? minor_nxt : major_nxt;
    nx_y    = e_steep ? major_nxt : minor_nxt;
  end

  assign active_nxt    = emit ? !last : active_r;
  assign pix_valid_nxt = emit ? 1'b1 : (pix_ready ? 1'b0 : pix_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      pix_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      pix_valid_r <= pix_valid_nxt;
    end
  end

  // State and pixel payload
  always_ff @(posedge clk) begin
    if (emit) begin
      major_end_r <= e_end;
      tmin_r      <= e_tmin;
      tmaj_r      <= e_tmaj;
      neg_r       <= e_neg;
      steep_r     <= e_steep;
      color_r     <= e_color;
      cur_x_r     <= last ? e_x : nx_x;
      cur_y_r     <= last ? e_y : nx_y;
      decision_r  <= last ? e_dec : dec_nxt;
      pix_x_r     <= e_x;
      pix_y_r     <= e_y;
      pix_color_r <= e_color;
      pix_last_r  <= last;
    end
  end

  assign pix_valid = pix_valid_r;
  assign pix_x     = pix_x_r;
  assign pix_y     = pix_y_r;
  assign pix_color = pix_color_r;
  assign pix_last  = pix_last_r;
  assign stat.pop  = pop;
  assign stat.emit = emit;

endmodule

`default_nettype wire

FILE: hw/rtl/brl_emit.sv
// ----------------------------------------------------------------------------
// brl_emit
// Viewport registers, clip test and framebuffer index (x + y * width);
// drives the registered result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module brl_emit #(
  parameter int COORD_BITS = brl_pkg::COORD_BITS_DEF,
  parameter int INDEX_BITS = brl_pkg::INDEX_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           pix_valid,
  output logic                           pix_ready,
  input  logic signed [COORD_BITS-1:0]   pix_x,
  input  logic signed [COORD_BITS-1:0]   pix_y,
  input  logic [brl_pkg::COLOR_BITS-1:0] pix_color,
  input  logic                           pix_last,
  brl_cfg_if.sink                        cfg_ch,
  brl_out_if.source                      out_ch
);

  localparam int CB    = COORD_BITS;
  localparam int RB    = brl_pkg::REG_BITS;
  localparam int CMP_W = (CB - 1 > RB) ? CB - 1 : RB;
  localparam int SUM_W = (CB + RB > INDEX_BITS) ? CB + RB : INDEX_BITS;

  logic [RB-1:0] view_w_r, view_h_r;

  // Configuration writes, always taken
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      view_w_r <= brl_pkg::VIEW_WIDTH_RESET;
      view_h_r <= brl_pkg::VIEW_HEIGHT_RESET;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        brl_pkg::CFG_VIEW_WIDTH:  view_w_r <= cfg_ch.data;
        brl_pkg::CFG_VIEW_HEIGHT: view_h_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // Clip test and stride multiply
  logic                  in_view;
  logic [CB-2:0]         xu, yu;
  logic [SUM_W-1:0]      index_sum;
  logic [INDEX_BITS-1:0] index;

  always_comb begin
    xu        = pix_x[CB-2:0];
    yu        = pix_y[CB-2:0];
    in_view   = !pix_x[CB-1] && !pix_y[CB-1] &&
                (CMP_W'(xu) < CMP_W'(view_w_r)) && (CMP_W'(yu) < CMP_W'(view_h_r));
    index_sum = SUM_W'(xu) + SUM_W'(yu) * SUM_W'(view_w_r);
    index     = in_view ? index_sum[INDEX_BITS-1:0] : '0;
  end

  // Output register
  logic                           out_valid_r, out_valid_nxt;
  logic signed [CB-1:0]           out_x_r, out_y_r;
  logic [INDEX_BITS-1:0]          out_index_r;
  logic                           out_inside_r, out_last_r;
  logic [brl_pkg::COLOR_BITS-1:0] out_color_r;
  logic                           take;

  assign pix_ready     = !out_valid_r || out_ch.ready;
  assign take          = pix_valid && pix_ready;
  assign out_valid_nxt = pix_ready ? pix_valid : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_x_r      <= pix_x;
      out_y_r      <= pix_y;
      out_index_r  <= index;
      out_inside_r <= in_view;
      out_color_r  <= pix_color;
      out_last_r   <= pix_last;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.pixel_x     = out_x_r;
  assign out_ch.pixel_y     = out_y_r;
  assign out_ch.pixel_index = out_index_r;
  assign out_ch.inside_res  = out_inside_r;
  assign out_ch.pixel_color = out_color_r;
  assign out_ch.last        = out_last_r;

endmodule

`default_nettype wire
